// ===== design/gabt_pkg.sv =====
// Shared types and constants for the group address binding table.
package gabt_pkg;

   localparam int HANDLER_LIMIT = 16;
   localparam int MAX_RESULTS   = 16;
   localparam int RES_W         = $clog2(MAX_RESULTS + 1);
   localparam int CSR_DATA_W    = 5;

   // commands
   localparam logic [1:0] CMD_ASSIGN   = 2'd0;
   localparam logic [1:0] CMD_UNASSIGN = 2'd1;
   localparam logic [1:0] CMD_DISPATCH = 2'd2;
   localparam logic [1:0] CMD_RESERVED = 2'd3;

   // result status codes
   localparam logic [2:0] ST_ADDED    = 3'd0;
   localparam logic [2:0] ST_PRESENT  = 3'd1;
   localparam logic [2:0] ST_FULL     = 3'd2;
   localparam logic [2:0] ST_BAD_ID   = 3'd3;
   localparam logic [2:0] ST_REMOVED  = 3'd4;
   localparam logic [2:0] ST_NONE_REM = 3'd5;
   localparam logic [2:0] ST_MATCH    = 3'd6;
   localparam logic [2:0] ST_NO_MATCH = 3'd7;

   // register indexes
   localparam logic CSR_HANDLER_COUNT  = 1'b0;
   localparam logic CSR_ALLOW_MULTIPLE = 1'b1;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] group_address;
      logic [3:0]  handler_id;
      logic [15:0] enable_mask;
   } gabt_req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [3:0] entry_index;
      logic [3:0] matched_handler;
      logic [4:0] removed_count;
      logic       last;
   } gabt_rsp_type;

   typedef struct packed {
      logic [15:0] group_address;
      logic [3:0]  handler_id;
   } gabt_entry_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FINISH
   } gabt_state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic scan;
      logic finish;
   } gabt_ctl_type;

   // datapath -> controller
   typedef struct packed {
      logic more;   // entries left to read
      logic stop;   // scan may end on this entry
      logic early;  // assign with an invalid id
   } gabt_sts_type;

endpackage

// ===== design/group_address_binding_table.sv =====
// Top level of the group address binding table.
//
// Use: an item (cmd, group_address, handler_id, enable_mask) is taken at a
// rising edge with start high and busy low. Assign adds a pair, unassign
// removes every identical pair and compacts the table, dispatch streams the
// enabled handlers bound to the destination address (with allow-multiple 0 the scan ends at the first bound handler).
// Results leave on rsp_item, one beat per cycle marked by rsp_strobe; the
// receiver cannot hold them off, so every beat must be taken as it shows.
// The final beat of an item has last set; the reserved command gives none.
// Registers are written on the csr_ port (csr_we, csr_index, csr_wdata):
// index 0 handler count, index 1 allow-multiple. The user must write them
// only while busy is low; the block itself does not enforce it.
// Timing: the table RAM is read one entry a cycle during the scan, and the
// final beat shows in the first cycle with busy low; a new item can be
// taken in that same cycle. A new item is taken only while busy is low.
// Dispatch matches stream out during the scan: each match is held until the
// next enabled hit, and its beat shows the cycle after that hit.
// Reset: synchronous, active high; empties the table, handler count 0,
// allow-multiple 1. The RAM itself is not cleared: only slots below the
// entry count are read.
module group_address_binding_table #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   // item channel
   input  logic                            start,
   output logic                            busy,
   input  gabt_pkg::gabt_req_type          req_item,
   // result channel
   output logic                            rsp_strobe,
   output gabt_pkg::gabt_rsp_type          rsp_item,
   // register write port
   input  logic                            csr_we,
   input  logic                            csr_index,
   input  logic [gabt_pkg::CSR_DATA_W-1:0] csr_wdata
);

   gabt_pkg::gabt_ctl_type ctl;
   gabt_pkg::gabt_sts_type sts;

   gabt_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_cmd (req_item.cmd),
      .sts     (sts),
      .ctl     (ctl),
      .busy    (busy)
   );

   gabt_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_item   (req_item),
      .ctl        (ctl),
      .sts        (sts),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

// ===== design/gabt_ram.sv =====
// Generic single write port RAM with registered read.
module gabt_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/gabt_ctrl.sv =====
// Sequencing state machine for the binding table.
module gabt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [1:0]            req_cmd,
   input  gabt_pkg::gabt_sts_type sts,
   output gabt_pkg::gabt_ctl_type ctl,
   output logic                  busy
);

   gabt_pkg::gabt_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gabt_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      ctl.load   = 1'b0;
      ctl.scan   = 1'b0;
      ctl.finish = 1'b0;
      case (state_ff)
         gabt_pkg::S_IDLE: begin
            ctl.load = start;
            // reserved command: taken, no work, no beat
            if (start && (req_cmd inside {gabt_pkg::CMD_ASSIGN, gabt_pkg::CMD_UNASSIGN,
                                         gabt_pkg::CMD_DISPATCH})) begin
               state_in = gabt_pkg::S_SCAN;
            end
         end
         gabt_pkg::S_SCAN: begin
            ctl.scan = 1'b1;
            if (sts.early || sts.stop || !sts.more) begin
               state_in = gabt_pkg::S_FINISH;
            end
         end
         gabt_pkg::S_FINISH: begin
            ctl.finish = 1'b1;
            state_in   = gabt_pkg::S_IDLE;
         end
         default: begin
            state_in = gabt_pkg::S_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != gabt_pkg::S_IDLE);

endmodule

// ===== design/gabt_datapath.sv =====
// Table storage, scan pointers, compaction and result formatting.
module gabt_datapath #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic                              csr_index,
   input  logic [gabt_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  gabt_pkg::gabt_req_type            req_item,
   input  gabt_pkg::gabt_ctl_type            ctl,
   output gabt_pkg::gabt_sts_type            sts,
   output logic                              rsp_strobe,
   output gabt_pkg::gabt_rsp_type            rsp_item
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int EW = $bits(gabt_pkg::gabt_entry_type);
   localparam int RW = gabt_pkg::RES_W;

   // configuration
   logic [4:0] hc_ff, hc_in;
   logic       am_ff, am_in;

   // item and scan state
   gabt_pkg::gabt_req_type item_ff, item_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] proc_ff, proc_in;
   logic          pv_ff, pv_in;
   logic [CW-1:0] kept_ff, kept_in;
   logic [CW-1:0] removed_ff, removed_in;
   logic [RW-1:0] n_ff, n_in;
   logic          held_v_ff, held_v_in;
   logic [3:0]    held_idx_ff, held_idx_in;
   logic [3:0]    held_hid_ff, held_hid_in;

   logic                   rsp_strobe_ff, rsp_strobe_in;
   gabt_pkg::gabt_rsp_type rsp_ff, rsp_in;

   // RAM port
   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [EW-1:0] wr_data, rd_data;

   gabt_pkg::gabt_entry_type entry;
   logic more, ent_id_ok, req_id_ok, early, addr_eq, pair_eq, hit, fire, stop;

   gabt_ram #(
      .WIDTH (EW),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      entry     = gabt_pkg::gabt_entry_type'(rd_data);
      more      = (rd_ptr_ff < count_ff);
      ent_id_ok = (int'(entry.handler_id) < int'(hc_ff)) &&
                  (int'(entry.handler_id) < gabt_pkg::HANDLER_LIMIT);
      req_id_ok = (int'(item_ff.handler_id) < int'(hc_ff)) &&
                  (int'(item_ff.handler_id) < gabt_pkg::HANDLER_LIMIT);
      early     = (item_ff.cmd == gabt_pkg::CMD_ASSIGN) && !req_id_ok;
      addr_eq   = (entry.group_address == item_ff.group_address);
      pair_eq   = addr_eq && (entry.handler_id == item_ff.handler_id);
      hit       = addr_eq && ent_id_ok;
      fire      = hit && item_ff.enable_mask[entry.handler_id];
      stop      = ctl.scan && pv_ff &&
                  (((item_ff.cmd == gabt_pkg::CMD_ASSIGN) && pair_eq) ||
                   ((item_ff.cmd == gabt_pkg::CMD_DISPATCH) && hit &&
                    (!am_ff || (fire && (n_ff == RW'(gabt_pkg::MAX_RESULTS - 1))))));
      sts.more  = more;
      sts.stop  = stop;
      sts.early = early;
   end

   always_comb begin
      hc_in         = hc_ff;
      am_in         = am_ff;
      item_in       = item_ff;
      count_in      = count_ff;
      rd_ptr_in     = rd_ptr_ff;
      proc_in       = proc_ff;
      pv_in         = 1'b0;
      kept_in       = kept_ff;
      removed_in    = removed_ff;
      n_in          = n_ff;
      held_v_in     = held_v_ff;
      held_idx_in   = held_idx_ff;
      held_hid_in   = held_hid_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      wr_en         = 1'b0;
      wr_addr       = kept_ff[AW-1:0];
      wr_data       = rd_data;
      rd_en         = 1'b0;
      rd_addr       = rd_ptr_ff[AW-1:0];

      if (csr_we) begin
         case (csr_index)
            gabt_pkg::CSR_HANDLER_COUNT:  hc_in = csr_wdata;
            gabt_pkg::CSR_ALLOW_MULTIPLE: am_in = csr_wdata[0];
            default: ;
         endcase
      end

      if (ctl.load) begin
         item_in    = req_item;
         rd_ptr_in  = '0;
         kept_in    = '0;
         removed_in = '0;
         n_in       = '0;
         held_v_in  = 1'b0;
      end

      if (ctl.scan) begin
         // read one entry a cycle; data is worked on the cycle after
         if (more) begin
            rd_en     = 1'b1;
            rd_ptr_in = rd_ptr_ff + CW'(1);
            pv_in     = 1'b1;
            proc_in   = rd_ptr_ff;
         end
         if (pv_ff) begin
            case (item_ff.cmd)
               gabt_pkg::CMD_ASSIGN: begin
                  if (pair_eq) begin
                     held_v_in   = 1'b1;
                     held_idx_in = 4'(proc_ff);
                  end
               end
               gabt_pkg::CMD_UNASSIGN: begin
                  // compaction: survivors move down to the kept slot
                  if (pair_eq) begin
                     removed_in = removed_ff + CW'(1);
                  end else begin
                     wr_en   = 1'b1;
                     wr_addr = kept_ff[AW-1:0];
                     wr_data = rd_data;
                     kept_in = kept_ff + CW'(1);
                  end
               end
               gabt_pkg::CMD_DISPATCH: begin
                  // one match held back so the final beat can carry last
                  if (fire) begin
                     if (held_v_ff) begin
                        rsp_strobe_in          = 1'b1;
                        rsp_in                 = '0;
                        rsp_in.status          = gabt_pkg::ST_MATCH;
                        rsp_in.entry_index     = held_idx_ff;
                        rsp_in.matched_handler = held_hid_ff;
                     end
                     held_v_in   = 1'b1;
                     held_idx_in = 4'(proc_ff);
                     held_hid_in = entry.handler_id;
                     n_in        = n_ff + RW'(1);
                  end
               end
               default: ;
            endcase
         end
      end

      if (ctl.finish) begin
         rsp_strobe_in = 1'b1;
         rsp_in        = '0;
         rsp_in.last   = 1'b1;
         case (item_ff.cmd)
            gabt_pkg::CMD_ASSIGN: begin
               if (early) begin
                  rsp_in.status = gabt_pkg::ST_BAD_ID;
               end else if (held_v_ff) begin
                  rsp_in.status      = gabt_pkg::ST_PRESENT;
                  rsp_in.entry_index = held_idx_ff;
               end else if (count_ff >= CW'(TABLE_DEPTH)) begin
                  rsp_in.status = gabt_pkg::ST_FULL;
               end else begin
                  wr_en              = 1'b1;
                  wr_addr            = count_ff[AW-1:0];
                  wr_data            = {item_ff.group_address, item_ff.handler_id};
                  rsp_in.status      = gabt_pkg::ST_ADDED;
                  rsp_in.entry_index = 4'(count_ff);
                  count_in           = count_ff + CW'(1);
               end
            end
            gabt_pkg::CMD_UNASSIGN: begin
               count_in             = kept_ff;
               rsp_in.status        = (removed_ff != '0) ? gabt_pkg::ST_REMOVED
                                                         : gabt_pkg::ST_NONE_REM;
               rsp_in.removed_count = 5'(removed_ff);
            end
            default: begin
               if (held_v_ff) begin
                  rsp_in.status          = gabt_pkg::ST_MATCH;
                  rsp_in.entry_index     = held_idx_ff;
                  rsp_in.matched_handler = held_hid_ff;
               end else begin
                  rsp_in.status = gabt_pkg::ST_NO_MATCH;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hc_ff         <= '0;
         am_ff         <= 1'b1;
         count_ff      <= '0;
         rd_ptr_ff     <= '0;
         pv_ff         <= 1'b0;
         kept_ff       <= '0;
         removed_ff    <= '0;
         n_ff          <= '0;
         held_v_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         hc_ff         <= hc_in;
         am_ff         <= am_in;
         count_ff      <= count_in;
         rd_ptr_ff     <= rd_ptr_in;
         pv_ff         <= pv_in;
         kept_ff       <= kept_in;
         removed_ff    <= removed_in;
         n_ff          <= n_in;
         held_v_ff     <= held_v_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      proc_ff     <= proc_in;
      held_idx_ff <= held_idx_in;
      held_hid_ff <= held_hid_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_kept_bound: assert property (@(posedge clock) disable iff (reset)
      kept_ff <= count_ff)
      else $error("compaction pointer passed entry count");

   a_result_bound: assert property (@(posedge clock) disable iff (reset)
      n_ff <= RW'(gabt_pkg::MAX_RESULTS))
      else $error("too many dispatch results");

   a_finish_beat: assert property (@(posedge clock) disable iff (reset)
      ctl.finish |=> (rsp_strobe && rsp_item.last))
      else $error("finish without a final beat");

endmodule
